// ----- rtl/core/tgi_pkg.sv -----
// Shared types and constants of the terrain grid interpolator.
// Used by the channel interfaces and the top level.
// No dependencies.
package tgi_pkg;

    // Default sizing of the height store and of the largest grid side
    localparam int unsigned GRID_CELLS_DEF = 65536;
    localparam int unsigned MAX_SIDE_DEF   = 256;

    // Fixed field widths
    localparam int unsigned HEIGHT_W   = 16;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned INDEX_W    = 16;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned COORD_W    = POS_W - FRAC_BITS;
    localparam int unsigned REG_SIDE_W = 9;
    localparam int unsigned CFG_DATA_W = 16;

    // Command opcodes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_QUERY = 2'd1,
        OP_MAX   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_GRID_WIDTH     = 2'd0,
        CFG_GRID_HEIGHT    = 2'd1,
        CFG_SPECIAL_LIMIT  = 2'd2,
        CFG_INVALID_HEIGHT = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [REG_SIDE_W-1:0]      GRID_WIDTH_RST     = 9'd256;
    localparam logic [REG_SIDE_W-1:0]      GRID_HEIGHT_RST    = 9'd256;
    localparam logic signed [HEIGHT_W-1:0] SPECIAL_LIMIT_RST  = 16'sh8AD0;  // -30000
    localparam logic signed [HEIGHT_W-1:0] INVALID_HEIGHT_RST = 16'sh8000;  // -32768

endpackage

// ----- rtl/core/tgi_if.sv -----
// Valid/ready channel interfaces of the terrain grid interpolator:
// command, response and configuration write.
// Depends on tgi_pkg.
interface tgi_cmd_if;
    logic                                 valid;
    logic                                 ready;
    tgi_pkg::opcode_t                     opcode;
    logic [tgi_pkg::INDEX_W-1:0]          cell_index;
    logic signed [tgi_pkg::HEIGHT_W-1:0]  cell_value;
    logic [tgi_pkg::POS_W-1:0]            x_pos;
    logic [tgi_pkg::POS_W-1:0]            y_pos;

    modport source (output valid, opcode, cell_index, cell_value, x_pos, y_pos,
                    input ready);
    modport sink   (input valid, opcode, cell_index, cell_value, x_pos, y_pos,
                    output ready);
endinterface

interface tgi_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tgi_pkg::HEIGHT_W-1:0]  result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

interface tgi_cfg_if;
    logic                                 valid;
    logic                                 ready;
    tgi_pkg::cfg_index_t                  index;
    logic [tgi_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/terrain_grid_interpolator_unit.sv -----
// Terrain grid interpolator: one item at a time. An interpolated query runs
// RED_STEPS compare/subtract steps that fold the four corner addresses into
// the store, and the four corners come one per cycle from the single read
// port of the height RAM. A maximum query walks min(width * height,
// GRID_CELLS) cells through that port, one per cycle; before any write it
// answers 0. The result sits in an output register, so the next command is
// taken while the previous result still waits. Configuration writes are
// always taken and must only happen while the block is idle. Heights read
// from cells never written are undefined.
// Depends on tgi_pkg, tgi_if.sv and tgi_ram.
module terrain_grid_interpolator_unit #(
    parameter int unsigned GRID_CELLS = tgi_pkg::GRID_CELLS_DEF,
    parameter int unsigned MAX_SIDE   = tgi_pkg::MAX_SIDE_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tgi_cfg_if.sink   cfg,
    tgi_cmd_if.sink   cmd,
    tgi_rsp_if.source rsp
);

    localparam int unsigned HW        = tgi_pkg::HEIGHT_W;
    localparam int unsigned CW        = tgi_pkg::COORD_W;
    localparam int unsigned FB        = tgi_pkg::FRAC_BITS;
    localparam int unsigned CELL_AW   = $clog2(GRID_CELLS);
    localparam int unsigned SIDE_W    = $clog2(MAX_SIDE + 1);
    localparam int unsigned RAW_MAX   = 256 * MAX_SIDE + 256;
    localparam int unsigned RAW_W     = $clog2(RAW_MAX + 1);
    localparam int unsigned RED_STEPS = (RAW_W > CELL_AW) ? RAW_W - CELL_AW + 1 : 1;
    localparam int unsigned STEP_W    = $clog2(RED_STEPS + 1);
    localparam int unsigned LANE_W    = ((RAW_W > CELL_AW) ? RAW_W : CELL_AW) + 1;
    localparam int unsigned WALK_W    = $clog2(GRID_CELLS + 1);
    localparam int unsigned AREA_W    = 2 * SIDE_W;
    localparam int unsigned DIFF_W    = HW + 1;
    localparam int unsigned PROD_W    = DIFF_W + CW + 1;
    localparam int unsigned ACC_W     = PROD_W + 1;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ADDR = 8'b0000_0010,
        ST_RED  = 8'b0000_0100,
        ST_READ = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_SUM  = 8'b0010_0000,
        ST_MAX  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    // Clamp a configured side to 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] side_of(input logic [tgi_pkg::REG_SIDE_W-1:0] r);
        logic [SIDE_W-1:0] s;
        if (r == '0)
        begin
            s = SIDE_W'(1);
        end
        else if (32'(r) > MAX_SIDE)
        begin
            s = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            s = SIDE_W'(r);
        end
        return s;
    endfunction

    // Control registers
    state_t                             state_reg, state_next;
    logic [tgi_pkg::REG_SIDE_W-1:0]     grid_width_reg, grid_width_next;
    logic [tgi_pkg::REG_SIDE_W-1:0]     grid_height_reg, grid_height_next;
    logic signed [HW-1:0]               special_limit_reg, special_limit_next;
    logic signed [HW-1:0]               invalid_height_reg, invalid_height_next;
    logic                               any_written_reg, any_written_next;
    logic                               out_valid_reg, out_valid_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic [2:0]                         cnt_reg, cnt_next;
    logic [WALK_W-1:0]                  walk_cnt_reg, walk_cnt_next;
    logic [WALK_W-1:0]                  walk_lim_reg, walk_lim_next;
    logic                               rd_pend_reg, rd_pend_next;
    logic                               have_best_reg, have_best_next;

    // Payload registers
    logic signed [HW-1:0]               out_value_reg, out_value_next;
    logic signed [HW-1:0]               result_reg, result_next;
    logic [CW-1:0]                      col_reg, col_next;
    logic [CW-1:0]                      row_reg, row_next;
    logic [FB-1:0]                      fx_reg, fx_next;
    logic [FB-1:0]                      fy_reg, fy_next;
    logic [LANE_W-1:0]                  lane_reg [4];
    logic [LANE_W-1:0]                  lane_next [4];
    logic signed [HW-1:0]               corner_reg [4];
    logic signed [HW-1:0]               corner_next [4];
    logic signed [PROD_W-1:0]           p1_reg, p1_next;
    logic signed [PROD_W-1:0]           p2_reg, p2_next;

    // Datapath and RAM signals
    logic [SIDE_W-1:0]                  w_side, h_side;
    logic                               cmd_xfer;
    logic                               rsp_xfer;
    logic                               wr_in_range;
    logic                               ram_we;
    logic                               ram_re;
    logic [CELL_AW-1:0]                 ram_raddr;
    logic [HW-1:0]                      ram_rdata;
    logic [AREA_W-1:0]                  area;
    logic [LANE_W-1:0]                  base;
    logic [LANE_W-1:0]                  dx;
    logic [LANE_W-1:0]                  dy;
    logic [LANE_W-1:0]                  sub_val;
    logic [FB-1:0]                      fa, fb;
    logic signed [DIFF_W-1:0]           da, db;
    logic signed [ACC_W-1:0]            acc;
    logic signed [ACC_W-1:0]            acc_sh;
    logic signed [ACC_W-1:0]            sum;
    logic                               any_special;
    logic [1:0]                         cap_idx;

    assign w_side      = side_of(grid_width_reg);
    assign h_side      = side_of(grid_height_reg);
    assign cfg.ready   = 1'b1;
    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cmd_xfer    = cmd.valid && cmd.ready;
    assign rsp_xfer    = out_valid_reg && rsp.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.result_value = out_value_reg;

    // Cell writes go straight to the RAM at the command transfer
    assign wr_in_range = (32'(cmd.cell_index) < GRID_CELLS);
    assign ram_we      = cmd_xfer && (cmd.opcode == tgi_pkg::OP_WRITE) && wr_in_range;

    // Read port: corner fetch or maximum walk
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (state_reg == ST_READ && cnt_reg < 3'd4)
        begin
            ram_re    = 1'b1;
            ram_raddr = lane_reg[cnt_reg[1:0]][CELL_AW-1:0];
        end
        else if (state_reg == ST_MAX && walk_cnt_reg < walk_lim_reg)
        begin
            ram_re    = 1'b1;
            ram_raddr = walk_cnt_reg[CELL_AW-1:0];
        end
    end

    tgi_ram #(
        .WIDTH (HW),
        .DEPTH (GRID_CELLS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (CELL_AW'(cmd.cell_index)),
        .wdata (cmd.cell_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Address arithmetic for the query cell
    assign area    = AREA_W'(w_side) * AREA_W'(h_side);
    assign base    = LANE_W'(row_reg) * LANE_W'(w_side) + LANE_W'(col_reg);
    assign dx      = (32'(col_reg) + 32'd1 == 32'(w_side)) ? '0 : LANE_W'(1);
    assign dy      = (32'(row_reg) + 32'd1 == 32'(h_side)) ? '0 : LANE_W'(w_side);
    assign sub_val = LANE_W'(GRID_CELLS) << step_reg;
    assign cap_idx = 2'(cnt_reg - 3'd1);

    // Triangle selection and slopes; corners are base, right, down, diagonal
    always_comb
    begin
        if (fx_reg > fy_reg)
        begin
            fa = fx_reg;
            fb = fy_reg;
            da = DIFF_W'(corner_reg[1]) - DIFF_W'(corner_reg[0]);
            db = DIFF_W'(corner_reg[1]) - DIFF_W'(corner_reg[3]);
        end
        else
        begin
            fa = fy_reg;
            fb = fx_reg;
            da = DIFF_W'(corner_reg[2]) - DIFF_W'(corner_reg[0]);
            db = DIFF_W'(corner_reg[2]) - DIFF_W'(corner_reg[3]);
        end
    end

    assign any_special = (corner_reg[0] <= special_limit_reg) ||
                         (corner_reg[1] <= special_limit_reg) ||
                         (corner_reg[2] <= special_limit_reg) ||
                         (corner_reg[3] <= special_limit_reg);

    // Blend: base plus floor-shifted correction, truncated to the height width
    assign acc    = ACC_W'(p1_reg) - ACC_W'(p2_reg);
    assign acc_sh = acc >>> FB;
    assign sum    = ACC_W'(corner_reg[0]) + acc_sh;

    // Next-state logic
    always_comb
    begin
        state_next          = state_reg;
        grid_width_next     = grid_width_reg;
        grid_height_next    = grid_height_reg;
        special_limit_next  = special_limit_reg;
        invalid_height_next = invalid_height_reg;
        any_written_next    = any_written_reg;
        out_valid_next      = out_valid_reg;
        step_next           = step_reg;
        cnt_next            = cnt_reg;
        walk_cnt_next       = walk_cnt_reg;
        walk_lim_next       = walk_lim_reg;
        rd_pend_next        = rd_pend_reg;
        have_best_next      = have_best_reg;
        out_value_next      = out_value_reg;
        result_next         = result_reg;
        col_next            = col_reg;
        row_next            = row_reg;
        fx_next             = fx_reg;
        fy_next             = fy_reg;
        lane_next           = lane_reg;
        corner_next         = corner_reg;
        p1_next             = p1_reg;
        p2_next             = p2_reg;

        // Configuration writes
        if (cfg.valid)
        begin
            case (cfg.index)
                tgi_pkg::CFG_GRID_WIDTH:
                    grid_width_next = cfg.data[tgi_pkg::REG_SIDE_W-1:0];
                tgi_pkg::CFG_GRID_HEIGHT:
                    grid_height_next = cfg.data[tgi_pkg::REG_SIDE_W-1:0];
                tgi_pkg::CFG_SPECIAL_LIMIT:
                    special_limit_next = $signed(cfg.data[HW-1:0]);
                tgi_pkg::CFG_INVALID_HEIGHT:
                    invalid_height_next = $signed(cfg.data[HW-1:0]);
                default:
                    grid_width_next = grid_width_reg;
            endcase
        end

        // Output register drains on a response transfer
        if (rsp_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    result_next = '0;
                    state_next  = ST_DONE;
                    case (cmd.opcode)
                        tgi_pkg::OP_WRITE:
                        begin
                            if (wr_in_range)
                            begin
                                any_written_next = 1'b1;
                            end
                        end
                        tgi_pkg::OP_QUERY:
                        begin
                            col_next   = cmd.x_pos[tgi_pkg::POS_W-1:FB];
                            row_next   = cmd.y_pos[tgi_pkg::POS_W-1:FB];
                            fx_next    = cmd.x_pos[FB-1:0];
                            fy_next    = cmd.y_pos[FB-1:0];
                            state_next = ST_ADDR;
                        end
                        tgi_pkg::OP_MAX:
                        begin
                            if (any_written_reg)
                            begin
                                walk_cnt_next  = '0;
                                walk_lim_next  = (32'(area) > GRID_CELLS) ?
                                                 WALK_W'(GRID_CELLS) : WALK_W'(area);
                                rd_pend_next   = 1'b0;
                                have_best_next = 1'b0;
                                state_next     = ST_MAX;
                            end
                        end
                        default:
                            result_next = '0;
                    endcase
                end
            end

            // Range check and raw corner addresses
            ST_ADDR:
            begin
                if (32'(col_reg) >= 32'(w_side) || 32'(row_reg) >= 32'(h_side))
                begin
                    result_next = invalid_height_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    lane_next[0] = base;
                    lane_next[1] = base + dx;
                    lane_next[2] = base + dy;
                    lane_next[3] = base + dx + dy;
                    step_next    = STEP_W'(RED_STEPS - 1);
                    state_next   = ST_RED;
                end
            end

            // Fold addresses into the store, one shifted subtract per cycle
            ST_RED:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (lane_reg[i] >= sub_val)
                    begin
                        lane_next[i] = lane_reg[i] - sub_val;
                    end
                end
                if (step_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            // Four corner reads; data lands in the cycle after each address
            ST_READ:
            begin
                if (cnt_reg != 3'd0)
                begin
                    corner_next[cap_idx] = $signed(ram_rdata);
                end
                if (cnt_reg == 3'd4)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end

            // Special-value bypass or the two slope products
            ST_MUL:
            begin
                if (any_special)
                begin
                    result_next = corner_reg[0];
                    state_next  = ST_DONE;
                end
                else
                begin
                    p1_next    = $signed({1'b0, fa}) * da;
                    p2_next    = $signed({1'b0, fb}) * db;
                    state_next = ST_SUM;
                end
            end

            ST_SUM:
            begin
                result_next = sum[HW-1:0];
                state_next  = ST_DONE;
            end

            // Maximum walk over the cells in use
            ST_MAX:
            begin
                if (walk_cnt_reg < walk_lim_reg)
                begin
                    walk_cnt_next = walk_cnt_reg + WALK_W'(1);
                    rd_pend_next  = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                if (rd_pend_reg)
                begin
                    have_best_next = 1'b1;
                    if (!have_best_reg || $signed(ram_rdata) > result_reg)
                    begin
                        result_next = $signed(ram_rdata);
                    end
                end
                if (walk_cnt_reg >= walk_lim_reg && !rd_pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            grid_width_reg     <= tgi_pkg::GRID_WIDTH_RST;
            grid_height_reg    <= tgi_pkg::GRID_HEIGHT_RST;
            special_limit_reg  <= tgi_pkg::SPECIAL_LIMIT_RST;
            invalid_height_reg <= tgi_pkg::INVALID_HEIGHT_RST;
            any_written_reg    <= 1'b0;
            out_valid_reg      <= 1'b0;
            step_reg           <= '0;
            cnt_reg            <= '0;
            walk_cnt_reg       <= '0;
            walk_lim_reg       <= '0;
            rd_pend_reg        <= 1'b0;
            have_best_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            grid_width_reg     <= grid_width_next;
            grid_height_reg    <= grid_height_next;
            special_limit_reg  <= special_limit_next;
            invalid_height_reg <= invalid_height_next;
            any_written_reg    <= any_written_next;
            out_valid_reg      <= out_valid_next;
            step_reg           <= step_next;
            cnt_reg            <= cnt_next;
            walk_cnt_reg       <= walk_cnt_next;
            walk_lim_reg       <= walk_lim_next;
            rd_pend_reg        <= rd_pend_next;
            have_best_reg      <= have_best_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        result_reg    <= result_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        lane_reg      <= lane_next;
        corner_reg    <= corner_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
    end

    // Folded corner addresses always land inside the store
    a_lanes_folded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |->
            lane_reg[0] < LANE_W'(GRID_CELLS) && lane_reg[1] < LANE_W'(GRID_CELLS) &&
            lane_reg[2] < LANE_W'(GRID_CELLS) && lane_reg[3] < LANE_W'(GRID_CELLS))
        else $error("corner address not folded into the store");

    // The maximum walk never runs past its limit
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAX |-> walk_cnt_reg <= walk_lim_reg)
        else $error("maximum walk past its limit");

    // Once any cell is written the flag stays set
    a_written_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        any_written_reg |=> any_written_reg)
        else $error("written flag dropped");

    // A query transfer starts the address phase
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_xfer && cmd.opcode == tgi_pkg::OP_QUERY |=> state_reg == ST_ADDR)
        else $error("query did not start address phase");

    // The output register is loaded only when it is free or being drained
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_valid_reg && !rsp.ready |=> state_reg == ST_DONE)
        else $error("result left while the output register was full");

endmodule

// ----- rtl/core/tgi_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tgi_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
